@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ sv/hmv_pkg.sv @@
// Types and constants of the histogram mean and variance block.
package hmv_pkg;

  localparam int unsigned MaxBinsDef = 1024;
  localparam int unsigned AccW       = 160;

  localparam logic [1:0] RegRangeLow  = 2'd0;
  localparam logic [1:0] RegRangeHigh = 2'd1;
  localparam logic [1:0] RegBinsInUse = 2'd2;

  typedef struct packed {
    logic [23:0] bin_count;
    logic        last_bin;
  } hmv_in_t;

  typedef struct packed {
    logic [33:0]        total_count;
    logic signed [31:0] mean_value;
    logic [47:0]        variance_value;
    logic               histogram_empty;
  } hmv_out_t;

endpackage

@@ sv/histogram_mean_variance.sv @@
// Histogram mean and variance: bin accumulation and shift-add/subtract sequencer.
// A bin is taken only in idle, then passes two multiply states and an accumulate state.
// After the last bin, a shared shift-add unit (skipped for an empty histogram) does each
// result multiply one multiplier bit a cycle and both restoring divisions at one quotient
// bit a cycle over 160 bits. The receiver cannot stall. Reset (rst_ni low, asynchronous)
// clears the sums and bin index and sets the range and bin registers to their defaults.
`include "assert_macros.svh"
module histogram_mean_variance #(
  parameter int unsigned MAX_BINS = hmv_pkg::MaxBinsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  hmv_pkg::hmv_in_t   bin_i,
  output logic               result_valid_o,
  output hmv_pkg::hmv_out_t  res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hmv_pkg::*;

  localparam int unsigned W = AccW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StBinM1 = 4'd1;
  localparam logic [3:0] StBinM2 = 4'd2;
  localparam logic [3:0] StBinAc = 4'd3;
  localparam logic [3:0] StSetup = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;

  localparam logic [4:0] SpDenM   = 5'd0;
  localparam logic [4:0] SpLow    = 5'd1;
  localparam logic [4:0] SpDiff   = 5'd2;
  localparam logic [4:0] SpNeg    = 5'd3;
  localparam logic [4:0] SpHalfM  = 5'd4;
  localparam logic [4:0] SpDivM   = 5'd5;
  localparam logic [4:0] SpMean   = 5'd6;
  localparam logic [4:0] SpS0S2   = 5'd7;
  localparam logic [4:0] SpS1S1   = 5'd8;
  localparam logic [4:0] SpX12    = 5'd9;
  localparam logic [4:0] SpS0S0   = 5'd10;
  localparam logic [4:0] SpDsq    = 5'd11;
  localparam logic [4:0] SpSq     = 5'd12;
  localparam logic [4:0] SpNb1    = 5'd13;
  localparam logic [4:0] SpNb2    = 5'd14;
  localparam logic [4:0] SpX3     = 5'd15;
  localparam logic [4:0] SpHalfV  = 5'd16;
  localparam logic [4:0] SpDivV   = 5'd17;
  localparam logic [4:0] SpOut    = 5'd18;

  logic [3:0]  state_q;
  logic [4:0]  step_q;
  logic [31:0] low_q, high_q;
  logic [10:0] bins_q;
  logic [10:0] idx_q;
  logic [33:0] s0_q;
  logic [43:0] s1_q;
  logic [53:0] s2_q;
  logic [23:0] c_q;
  logic        last_q;
  logic [34:0] p1_q;
  logic [45:0] p2_q;
  logic [W-1:0] acc_q, ma_q, dreg_q, nreg_q, rem_q;
  logic [63:0] mb_q, dsq_q;
  logic        sub_q, neg_q, ovf_q;
  logic [47:0] q_q;
  logic [7:0]  cnt_q;
  logic [31:0] mean_q;
  logic        done_q;
  hmv_out_t    res_q;

  logic        cfg_wr;
  logic [10:0] nb;
  logic signed [32:0] dval;
  logic [32:0] dmag;
  logic [45:0] ew;
  logic [34:0] mop;
  logic [45:0] bin_prod;
  logic [W-1:0] add_a, add_b;
  logic        add_sub;
  logic [W:0]  add_sum;
  logic        mean_sat;
  logic [31:0] mean_mag, mean_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy = (state_q != StIdle);
  assign result_valid_o = done_q;
  assign res_o = res_q;

  always_comb begin
    case (paddr[3:2])
      RegRangeLow:  prdata = low_q;
      RegRangeHigh: prdata = high_q;
      RegBinsInUse: prdata = {21'd0, bins_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (bins_q == 11'd0) begin
      nb = 11'd1;
    end else if (bins_q > 11'(MAX_BINS)) begin
      nb = 11'(MAX_BINS);
    end else begin
      nb = bins_q;
    end
  end

  assign dval = {high_q[31], high_q} - {low_q[31], low_q};
  assign dmag = dval[32] ? 33'(-dval) : 33'(dval);
  assign ew   = {1'b0, s1_q, 1'b0} + {12'd0, s0_q};

  // one small multiplier serves both per-bin products
  assign mop      = (state_q == StBinM1) ? {11'd0, c_q} : p1_q;
  assign bin_prod = {35'd0, idx_q} * {11'd0, mop};

  // shared add/subtract: multiply steps and restoring division steps
  always_comb begin
    if (state_q == StDiv) begin
      add_a   = {rem_q[W-2:0], acc_q[W-1]};
      add_b   = dreg_q;
      add_sub = 1'b1;
    end else begin
      add_a   = acc_q;
      add_b   = ma_q;
      add_sub = sub_q;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b ^ {W{add_sub}}} + {{W{1'b0}}, add_sub};
  end

  always_comb begin
    if (neg_q) begin
      mean_sat = ovf_q || (q_q > 48'h0000_8000_0000);
      mean_mag = mean_sat ? 32'h8000_0000 : q_q[31:0];
      mean_res = 32'd0 - mean_mag;
    end else begin
      mean_sat = ovf_q || (q_q > 48'h0000_7FFF_FFFF);
      mean_mag = q_q[31:0];
      mean_res = mean_sat ? 32'h7FFF_FFFF : q_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 32'd0;
      high_q <= 32'd65536;
      bins_q <= 11'd64;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegRangeLow:  low_q  <= pwdata;
        RegRangeHigh: high_q <= pwdata;
        RegBinsInUse: bins_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= SpDenM;
      done_q  <= 1'b0;
      idx_q   <= 11'd0;
      s0_q    <= 34'd0;
      s1_q    <= 44'd0;
      s2_q    <= 54'd0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            c_q     <= bin_i.bin_count;
            last_q  <= bin_i.last_bin;
            state_q <= StBinM1;
          end
        end
        StBinM1: begin
          p1_q    <= bin_prod[34:0];
          state_q <= StBinM2;
        end
        StBinM2: begin
          p2_q    <= bin_prod;
          state_q <= StBinAc;
        end
        StBinAc: begin
          if (idx_q < nb) begin
            s0_q <= s0_q + {10'd0, c_q};
            s1_q <= s1_q + {9'd0, p1_q};
            s2_q <= s2_q + {8'd0, p2_q};
          end
          if (idx_q != 11'h7FF) begin
            idx_q <= idx_q + 11'd1;
          end
          step_q  <= SpDenM;
          state_q <= last_q ? StSetup : StIdle;
        end
        StMul: begin
          if (mb_q == 64'd0) begin
            step_q  <= step_q + 5'd1;
            state_q <= StSetup;
          end else begin
            if (mb_q[0]) begin
              acc_q <= add_sum[W-1:0];
            end
            ma_q <= {ma_q[W-2:0], 1'b0};
            mb_q <= {1'b0, mb_q[63:1]};
          end
        end
        StDiv: begin
          if (add_sum[W]) begin
            rem_q <= add_sum[W-1:0];
          end else begin
            rem_q <= add_a;
          end
          acc_q <= {acc_q[W-2:0], 1'b0};
          q_q   <= {q_q[46:0], add_sum[W]};
          ovf_q <= ovf_q | q_q[47];
          if (cnt_q == 8'd0) begin
            step_q  <= step_q + 5'd1;
            state_q <= StSetup;
          end else begin
            cnt_q <= cnt_q - 8'd1;
          end
        end
        StSetup: begin
          state_q <= StMul;
          case (step_q)
            SpDenM: begin
              if (s0_q == 34'd0) begin
                res_q.total_count     <= 34'd0;
                res_q.mean_value      <= 32'sd0;
                res_q.variance_value  <= 48'd0;
                res_q.histogram_empty <= 1'b1;
                done_q  <= 1'b1;
                idx_q   <= 11'd0;
                state_q <= StIdle;
              end else begin
                ma_q  <= W'(s0_q);
                mb_q  <= 64'(nb);
                acc_q <= '0;
                sub_q <= 1'b0;
              end
            end
            SpLow: begin
              dreg_q <= {acc_q[W-2:0], 1'b0};
              ma_q   <= {{(W-32){low_q[31]}}, low_q};
              mb_q   <= {acc_q[62:0], 1'b0};
              acc_q  <= '0;
            end
            SpDiff: begin
              ma_q <= {{(W-33){dval[32]}}, dval};
              mb_q <= 64'(ew);
            end
            SpNeg: begin
              // take the magnitude of the mean numerator
              neg_q <= acc_q[W-1];
              if (acc_q[W-1]) begin
                ma_q  <= acc_q;
                acc_q <= '0;
                mb_q  <= 64'd1;
                sub_q <= 1'b1;
              end else begin
                mb_q <= 64'd0;
              end
            end
            SpHalfM: begin
              ma_q  <= {1'b0, dreg_q[W-1:1]};
              mb_q  <= 64'd1;
              sub_q <= 1'b0;
            end
            SpDivM, SpDivV: begin
              rem_q   <= '0;
              q_q     <= 48'd0;
              ovf_q   <= 1'b0;
              cnt_q   <= 8'(W - 1);
              state_q <= StDiv;
            end
            SpMean: begin
              mean_q <= mean_res;
              ma_q   <= W'(dmag);
              mb_q   <= 64'(dmag);
              acc_q  <= '0;
              sub_q  <= 1'b0;
            end
            SpS0S2: begin
              dsq_q <= acc_q[63:0];
              ma_q  <= W'(s0_q);
              mb_q  <= 64'(s2_q);
              acc_q <= '0;
            end
            SpS1S1: begin
              ma_q  <= W'(s1_q);
              mb_q  <= 64'(s1_q);
              sub_q <= 1'b1;
            end
            SpX12: begin
              ma_q  <= acc_q;
              mb_q  <= 64'd12;
              acc_q <= '0;
              sub_q <= 1'b0;
            end
            SpS0S0: begin
              ma_q <= W'(s0_q);
              mb_q <= 64'(s0_q);
            end
            SpDsq: begin
              ma_q  <= acc_q;
              mb_q  <= dsq_q;
              acc_q <= '0;
            end
            SpSq: begin
              nreg_q <= acc_q;
              ma_q   <= W'(s0_q);
              mb_q   <= 64'(s0_q);
              acc_q  <= '0;
            end
            SpNb1, SpNb2: begin
              ma_q  <= acc_q;
              mb_q  <= 64'(nb);
              acc_q <= '0;
            end
            SpX3: begin
              ma_q  <= acc_q;
              mb_q  <= 64'd3;
              acc_q <= '0;
            end
            SpHalfV: begin
              // divisor is 3*B^2*S0^2 scaled by 2^18; add half of it for rounding
              dreg_q <= {acc_q[W-19:0], 18'd0};
              ma_q   <= {acc_q[W-18:0], 17'd0};
              acc_q  <= nreg_q;
              mb_q   <= 64'd1;
            end
            SpOut: begin
              res_q.total_count     <= s0_q;
              res_q.mean_value      <= mean_q;
              res_q.variance_value  <= ovf_q ? {48{1'b1}} : q_q;
              res_q.histogram_empty <= 1'b0;
              done_q  <= 1'b1;
              idx_q   <= 11'd0;
              s0_q    <= 34'd0;
              s1_q    <= 44'd0;
              s2_q    <= 54'd0;
              state_q <= StIdle;
            end
            default: state_q <= StIdle;
          endcase
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy,
               "accepted bin did not raise busy")
  `ASSERT_NEXT(a_strobe_one, clk_i, rst_ni, result_valid_o, !result_valid_o,
               "result strobe held")
  `ASSERT_PROP(a_empty_zero, clk_i, rst_ni,
               (result_valid_o && res_o.histogram_empty) |->
               (res_o.mean_value == 32'sd0 && res_o.variance_value == 48'd0 &&
                res_o.total_count == 34'd0),
               "empty result not zero")
  `ASSERT_PROP(a_done_idle, clk_i, rst_ni, result_valid_o |-> !busy, "result while busy")

endmodule
